// ===== rtl/core/hrtb_pkg.sv =====
// Shared types, codes and constants for the heart-rate time-block histogram.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package hrtb_pkg;

   // Defaults for the top-level parameters.
   localparam int NUM_BLOCKS_DEF = 96;
   localparam int COUNT_BITS_DEF = 8;

   // Five rate bins per time block; this is fixed by the output fields.
   localparam int NUM_BINS = 5;
   localparam int BIN_W    = 3;

   // Width of a reported count and of the configuration data.
   localparam int OUT_W = 8;
   localparam int CSR_W = 8;
   localparam int CSR_IDX_W = 2;

   // Slot index width before the range check (hour * 4 + quarter).
   localparam int IDX_W = 8;

   // Time limits, quarter-hour boundaries and the frame terminator.
   localparam logic [7:0] HOUR_LAST    = 8'd23;
   localparam logic [7:0] MINUTE_LAST  = 8'd59;
   localparam logic [7:0] QUARTER_ONE  = 8'd15;
   localparam logic [7:0] QUARTER_TWO  = 8'd30;
   localparam logic [7:0] QUARTER_THREE = 8'd45;
   localparam logic [7:0] FRAME_END    = 8'd10;

   // Reset values of the bin edges.
   localparam logic [7:0] EDGE_LOW_RST    = 8'd40;
   localparam logic [7:0] EDGE_SECOND_RST = 8'd80;
   localparam logic [7:0] EDGE_THIRD_RST  = 8'd120;
   localparam logic [7:0] EDGE_HIGH_RST   = 8'd160;

   typedef enum logic [1:0] {
      MODE_RECORD     = 2'd0,
      MODE_QUERY_TIME = 2'd1,
      MODE_QUERY_LAST = 2'd2,
      MODE_CLEAR      = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_RECORDED   = 3'd0,
      ST_BAD_FRAME  = 3'd1,
      ST_BAD_TIME   = 3'd2,
      ST_QUERY_DONE = 3'd3,
      ST_CLEARED    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      WARN_NONE = 2'd0,
      WARN_LOW  = 2'd1,
      WARN_HIGH = 2'd2
   } warn_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EDGE_LOW    = 2'd0,
      CSR_EDGE_SECOND = 2'd1,
      CSR_EDGE_THIRD  = 2'd2,
      CSR_EDGE_HIGH   = 2'd3
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request fields
      logic lookup;    // compute the slot and bin, read the counter word
      logic exec;      // update the store and register the result
   } ctrl_cmd_type;

   // Quarter of the hour for a minute in range.
   function automatic logic [1:0] quarter_of(input logic [7:0] minute);
      logic [1:0] q;
      if (minute < QUARTER_ONE) begin
         q = 2'd0;
      end else if (minute < QUARTER_TWO) begin
         q = 2'd1;
      end else if (minute < QUARTER_THREE) begin
         q = 2'd2;
      end else begin
         q = 2'd3;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hrtb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module hrtb_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 96
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hrtb_ctrl.sv =====
// Controller for the heart-rate time-block histogram: sequences one item
// through capture, lookup and execute. Depends on hrtb_pkg.
`default_nettype none

module hrtb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output hrtb_pkg::ctrl_cmd_type     cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Next state: an item moves through lookup and execute, then the block is free.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   // State and registered busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   // Commands to the datapath.
   always_comb begin
      cmd.capture = start && !busy_ff;
      cmd.lookup  = (state_ff == S_LOOKUP);
      cmd.exec    = (state_ff == S_EXEC);
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hrtb_dp.sv =====
// Datapath for the heart-rate time-block histogram: request latch, slot and
// bin selection, counter store with valid bits, and the result register.
// Depends on hrtb_pkg and hrtb_ram.
`default_nettype none

module hrtb_dp #(
   parameter int NUM_BLOCKS = hrtb_pkg::NUM_BLOCKS_DEF,
   parameter int COUNT_BITS = hrtb_pkg::COUNT_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire hrtb_pkg::ctrl_cmd_type           cmd,
   // Request fields.
   input  wire logic [1:0]                       req_mode,
   input  wire logic [7:0]                       req_rate_bpm,
   input  wire logic [7:0]                       req_hour,
   input  wire logic [7:0]                       req_minute,
   input  wire logic [7:0]                       req_terminator,
   // Configuration writes.
   input  wire logic                             csr_write_en,
   input  wire logic [hrtb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [hrtb_pkg::CSR_W-1:0]       csr_data,
   // Result.
   output logic                                  rsp_strobe,
   output logic [2:0]                            rsp_status,
   output logic [1:0]                            rsp_warning,
   output logic [hrtb_pkg::BIN_W-1:0]            rsp_bin_hit,
   output logic [hrtb_pkg::OUT_W-1:0]            rsp_count [hrtb_pkg::NUM_BINS]
);

   localparam int SLOT_W = $clog2(NUM_BLOCKS);
   localparam int WORD_W = hrtb_pkg::NUM_BINS * COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // Bin edges.
   logic [7:0] edge_low_ff, edge_second_ff, edge_third_ff, edge_high_ff;

   // Captured request.
   hrtb_pkg::mode_type mode_ff;
   logic [7:0] rate_ff, hour_ff, minute_ff, term_ff;

   // Last recorded time.
   logic [4:0] last_hour_ff;
   logic [5:0] last_minute_ff;

   // Lookup results.
   logic [SLOT_W-1:0]          slot_ff;
   logic                       time_ok_ff, frame_ok_ff;
   logic [hrtb_pkg::BIN_W-1:0] bin_ff;

   // Block valid bits.
   logic [NUM_BLOCKS-1:0] valid_ff;

   // Result registers.
   logic                       strobe_ff;
   hrtb_pkg::status_type       status_ff, status_in;
   hrtb_pkg::warn_type         warn_ff, warn_in;
   logic [hrtb_pkg::BIN_W-1:0] hit_ff, hit_in;
   logic [COUNT_BITS-1:0]      cnt_ff [hrtb_pkg::NUM_BINS];
   logic [COUNT_BITS-1:0]      cnt_in [hrtb_pkg::NUM_BINS];

   // Lookup logic.
   logic [7:0]                 sel_hour, sel_minute;
   logic [hrtb_pkg::IDX_W-1:0] idx;
   logic                       time_ok;
   logic [hrtb_pkg::BIN_W-1:0] bin_sel;

   // Execute logic.
   logic [WORD_W-1:0] rd_word, base_word, new_word;
   logic              do_record, show_counts;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_low_ff    <= hrtb_pkg::EDGE_LOW_RST;
         edge_second_ff <= hrtb_pkg::EDGE_SECOND_RST;
         edge_third_ff  <= hrtb_pkg::EDGE_THIRD_RST;
         edge_high_ff   <= hrtb_pkg::EDGE_HIGH_RST;
      end else if (csr_write_en) begin
         case (hrtb_pkg::csr_index_type'(csr_index))
            hrtb_pkg::CSR_EDGE_LOW:    edge_low_ff    <= csr_data;
            hrtb_pkg::CSR_EDGE_SECOND: edge_second_ff <= csr_data;
            hrtb_pkg::CSR_EDGE_THIRD:  edge_third_ff  <= csr_data;
            hrtb_pkg::CSR_EDGE_HIGH:   edge_high_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= hrtb_pkg::mode_type'(req_mode);
         rate_ff   <= req_rate_bpm;
         hour_ff   <= req_hour;
         minute_ff <= req_minute;
         term_ff   <= req_terminator;
      end
   end

   // Slot selection: a last-block query uses the stored time.
   always_comb begin
      if (mode_ff == hrtb_pkg::MODE_QUERY_LAST) begin
         sel_hour   = {3'b000, last_hour_ff};
         sel_minute = {2'b00, last_minute_ff};
      end else begin
         sel_hour   = hour_ff;
         sel_minute = minute_ff;
      end
      idx     = {sel_hour[hrtb_pkg::IDX_W-3:0], 2'b00}
              | {{(hrtb_pkg::IDX_W-2){1'b0}}, hrtb_pkg::quarter_of(sel_minute)};
      time_ok = (sel_hour <= hrtb_pkg::HOUR_LAST)
             && (sel_minute <= hrtb_pkg::MINUTE_LAST)
             && (idx < hrtb_pkg::IDX_W'(NUM_BLOCKS));
   end

   // Rate bin: the first edge at or above the rate wins.
   always_comb begin
      if (rate_ff <= edge_low_ff) begin
         bin_sel = 3'd0;
      end else if (rate_ff <= edge_second_ff) begin
         bin_sel = 3'd1;
      end else if (rate_ff <= edge_third_ff) begin
         bin_sel = 3'd2;
      end else if (rate_ff <= edge_high_ff) begin
         bin_sel = 3'd3;
      end else begin
         bin_sel = 3'd4;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         slot_ff     <= idx[SLOT_W-1:0];
         time_ok_ff  <= time_ok;
         frame_ok_ff <= (term_ff == hrtb_pkg::FRAME_END);
         bin_ff      <= bin_sel;
      end
   end

   // Counter store, one word of five counters per block.
   hrtb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_BLOCKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.exec && do_record),
      .wr_addr (slot_ff),
      .wr_data (new_word),
      .rd_en   (cmd.lookup),
      .rd_addr (idx[SLOT_W-1:0]),
      .rd_data (rd_word)
   );

   // Execute: a block that is not valid reads as all zero.
   always_comb begin
      do_record = (mode_ff == hrtb_pkg::MODE_RECORD) && frame_ok_ff && time_ok_ff;
      base_word = valid_ff[slot_ff] ? rd_word : '0;
      new_word  = base_word;
      for (int b = 0; b < hrtb_pkg::NUM_BINS; b++) begin
         if (do_record && (bin_ff == hrtb_pkg::BIN_W'(b))
             && (base_word[b*COUNT_BITS +: COUNT_BITS] != CNT_MAX)) begin
            new_word[b*COUNT_BITS +: COUNT_BITS] =
               base_word[b*COUNT_BITS +: COUNT_BITS] + COUNT_BITS'(1);
         end
      end
   end

   // Result fields.
   always_comb begin
      warn_in     = hrtb_pkg::WARN_NONE;
      hit_in      = '0;
      show_counts = 1'b0;
      case (mode_ff)
         hrtb_pkg::MODE_RECORD: begin
            if (!frame_ok_ff) begin
               status_in = hrtb_pkg::ST_BAD_FRAME;
            end else if (!time_ok_ff) begin
               status_in = hrtb_pkg::ST_BAD_TIME;
            end else begin
               status_in   = hrtb_pkg::ST_RECORDED;
               hit_in      = bin_ff;
               show_counts = 1'b1;
               if (bin_ff == 3'd0) begin
                  warn_in = hrtb_pkg::WARN_LOW;
               end else if (bin_ff == 3'd4) begin
                  warn_in = hrtb_pkg::WARN_HIGH;
               end
            end
         end
         hrtb_pkg::MODE_QUERY_TIME, hrtb_pkg::MODE_QUERY_LAST: begin
            if (time_ok_ff) begin
               status_in   = hrtb_pkg::ST_QUERY_DONE;
               show_counts = 1'b1;
            end else begin
               status_in = hrtb_pkg::ST_BAD_TIME;
            end
         end
         default: begin
            status_in = hrtb_pkg::ST_CLEARED;
         end
      endcase
      for (int b = 0; b < hrtb_pkg::NUM_BINS; b++) begin
         cnt_in[b] = show_counts ? new_word[b*COUNT_BITS +: COUNT_BITS] : '0;
      end
   end

   // Store control state: valid bits and the last recorded time.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         last_hour_ff   <= '0;
         last_minute_ff <= '0;
      end else if (cmd.exec) begin
         if (mode_ff == hrtb_pkg::MODE_CLEAR) begin
            valid_ff <= '0;
         end else if (do_record) begin
            valid_ff[slot_ff] <= 1'b1;
            last_hour_ff      <= hour_ff[4:0];
            last_minute_ff    <= minute_ff[5:0];
         end
      end
   end

   // Result register; the strobe lasts one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         warn_ff   <= warn_in;
         hit_ff    <= hit_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Reported counts saturate at the output width.
   for (genvar g = 0; g < hrtb_pkg::NUM_BINS; g++) begin : g_sat
      if (COUNT_BITS > hrtb_pkg::OUT_W) begin : g_wide
         assign rsp_count[g] = (|cnt_ff[g][COUNT_BITS-1:hrtb_pkg::OUT_W])
                             ? {hrtb_pkg::OUT_W{1'b1}}
                             : cnt_ff[g][hrtb_pkg::OUT_W-1:0];
      end else begin : g_narrow
         assign rsp_count[g] = hrtb_pkg::OUT_W'(cnt_ff[g]);
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_status  = status_ff;
   assign rsp_warning = warn_ff;
   assign rsp_bin_hit = hit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/heart_rate_time_block_histogram.sv =====
// Top level of the heart-rate time-block histogram: controller and datapath.
// Depends on hrtb_pkg, hrtb_ctrl, hrtb_dp (and hrtb_ram below it).
//
//   Channel   Handshake               Ports
//   request   start, busy             req_mode, req_rate_bpm, req_hour,
//                                     req_minute, req_terminator
//   result    rsp_strobe (1 cycle)    rsp_status, rsp_warning, rsp_bin_hit,
//                                     rsp_count_bin0 .. rsp_count_bin4
//   config    csr_write_en            csr_index, csr_data
//
// An item is taken when start is high and busy is low. It passes through lookup
// (slot, bin, counter-word read) and then execute (counter update); its result
// is registered at the end of execute and is taken at the end of the strobe cycle.
// A new item is taken only once the last is through, at the edge that ends the result cycle.
// Clear empties the store through the valid bits and takes as long as any item.
// Reset is synchronous and needs no clearing pass; the receiver cannot stall results.
`default_nettype none

module heart_rate_time_block_histogram #(
   parameter int NUM_BLOCKS = hrtb_pkg::NUM_BLOCKS_DEF,
   parameter int COUNT_BITS = hrtb_pkg::COUNT_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_mode,
   input  wire logic [7:0]                     req_rate_bpm,
   input  wire logic [7:0]                     req_hour,
   input  wire logic [7:0]                     req_minute,
   input  wire logic [7:0]                     req_terminator,
   // Result channel.
   output logic                                rsp_strobe,
   output logic [2:0]                          rsp_status,
   output logic [1:0]                          rsp_warning,
   output logic [2:0]                          rsp_bin_hit,
   output logic [7:0]                          rsp_count_bin0,
   output logic [7:0]                          rsp_count_bin1,
   output logic [7:0]                          rsp_count_bin2,
   output logic [7:0]                          rsp_count_bin3,
   output logic [7:0]                          rsp_count_bin4,
   // Configuration port.
   input  wire logic                           csr_write_en,
   input  wire logic [hrtb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hrtb_pkg::CSR_W-1:0]     csr_data
);

   hrtb_pkg::ctrl_cmd_type       cmd;
   logic [hrtb_pkg::OUT_W-1:0]   counts [hrtb_pkg::NUM_BINS];

   // Sequencer.
   hrtb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Datapath with the counter store.
   hrtb_dp #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_rate_bpm   (req_rate_bpm),
      .req_hour       (req_hour),
      .req_minute     (req_minute),
      .req_terminator (req_terminator),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_warning    (rsp_warning),
      .rsp_bin_hit    (rsp_bin_hit),
      .rsp_count      (counts)
   );

   assign rsp_count_bin0 = counts[0];
   assign rsp_count_bin1 = counts[1];
   assign rsp_count_bin2 = counts[2];
   assign rsp_count_bin3 = counts[3];
   assign rsp_count_bin4 = counts[4];

   // Every accepted item gives its result strobe after lookup and execute.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("accepted item produced no result three cycles later");

   // A result is only shown once the block has finished the item.
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe without a completed item");

   // Warnings and bin hits belong to recorded samples only.
   a_warn_recorded: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != hrtb_pkg::ST_RECORDED))
         |-> (rsp_warning == hrtb_pkg::WARN_NONE && rsp_bin_hit == '0))
      else $error("warning or bin hit on a result that recorded nothing");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for heart_rate_time_block_histogram: directed table, then random phases.
// Each accepted item is scored against an in-bench histogram model, or typed rows against their own result.
// Depends on hrtb_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;

   typedef logic [hrtb_pkg::NUM_BINS-1:0][7:0] count_set_type;

   typedef struct packed {
      hrtb_pkg::mode_type mode;
      logic [7:0]         rate;
      logic [7:0]         hour;
      logic [7:0]         minute;
      logic [7:0]         term;
   } req_item_type;

   typedef struct packed {
      hrtb_pkg::status_type status;
      hrtb_pkg::warn_type   warning;
      logic [2:0]           bin_hit;
      count_set_type        counts;
   } hist_result_type;

   typedef struct packed {
      req_item_type    item;
      logic            typed;
      hist_result_type res;
   } plan_row_type;

   localparam int COUNT_FULL = (1 << hrtb_pkg::COUNT_BITS_DEF) - 1;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [1:0]                     req_mode = hrtb_pkg::MODE_RECORD;
   logic [7:0]                     req_rate_bpm = 8'd0;
   logic [7:0]                     req_hour = 8'd0;
   logic [7:0]                     req_minute = 8'd0;
   logic [7:0]                     req_terminator = 8'd0;
   logic                           rsp_strobe;
   logic [2:0]                     rsp_status;
   logic [1:0]                     rsp_warning;
   logic [2:0]                     rsp_bin_hit;
   logic [7:0]                     rsp_count_bin0, rsp_count_bin1, rsp_count_bin2;
   logic [7:0]                     rsp_count_bin3, rsp_count_bin4;
   logic                           csr_write_en = 1'b0;
   logic [hrtb_pkg::CSR_IDX_W-1:0] csr_index = hrtb_pkg::CSR_EDGE_LOW;
   logic [hrtb_pkg::CSR_W-1:0]     csr_data = 8'd0;

   // Model of the store and the bin edges.
   logic [7:0] bin_edge [4];
   int         slot_count [hrtb_pkg::NUM_BLOCKS_DEF][hrtb_pkg::NUM_BINS];
   bit         slot_live [hrtb_pkg::NUM_BLOCKS_DEF];
   logic [7:0] last_hr, last_min;

   hist_result_type pending_results [$];
   plan_row_type    plan [$];
   logic            cur_typed = 1'b0;
   hist_result_type cur_typed_res = '0;
   int              errors = 0;
   bit              no_idle = 1'b0;
   int              hot_hour, hot_quarter;

   heart_rate_time_block_histogram DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_rate_bpm(req_rate_bpm), .req_hour(req_hour),
      .req_minute(req_minute), .req_terminator(req_terminator),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_warning(rsp_warning),
      .rsp_bin_hit(rsp_bin_hit), .rsp_count_bin0(rsp_count_bin0),
      .rsp_count_bin1(rsp_count_bin1), .rsp_count_bin2(rsp_count_bin2),
      .rsp_count_bin3(rsp_count_bin3), .rsp_count_bin4(rsp_count_bin4),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Slot for a time of day, or -1 when the time is out of range.
   function automatic int slot_index(logic [7:0] hour, logic [7:0] minute);
      int idx;
      if (hour > 8'd23 || minute > 8'd59) return -1;
      idx = int'(hour) * 4 + int'(minute) / 15;
      if (idx >= hrtb_pkg::NUM_BLOCKS_DEF) return -1;
      return idx;
   endfunction

   // Reported counts of a slot; an empty slot reads as zero.
   function automatic count_set_type slot_view(int slot);
      count_set_type c;
      c = '0;
      if (slot >= 0 && slot_live[slot]) begin
         for (int b = 0; b < hrtb_pkg::NUM_BINS; b++) begin
            c[b] = (slot_count[slot][b] > 255) ? 8'd255 : 8'(slot_count[slot][b]);
         end
      end
      return c;
   endfunction

   // Expected result of one item; updates the model store as the block would.
   function automatic hist_result_type histogram_predict(req_item_type it);
      hist_result_type r;
      int              slot;
      int              bin;
      r = '0;
      case (it.mode)
         hrtb_pkg::MODE_RECORD: begin
            slot = slot_index(it.hour, it.minute);
            if (it.term != hrtb_pkg::FRAME_END) begin
               r.status = hrtb_pkg::ST_BAD_FRAME;
            end else if (slot < 0) begin
               r.status = hrtb_pkg::ST_BAD_TIME;
            end else begin
               // First edge at or above the rate wins, in bin order.
               if (it.rate <= bin_edge[0]) bin = 0;
               else if (it.rate <= bin_edge[1]) bin = 1;
               else if (it.rate <= bin_edge[2]) bin = 2;
               else if (it.rate <= bin_edge[3]) bin = 3;
               else bin = 4;
               if (!slot_live[slot]) begin
                  for (int b = 0; b < hrtb_pkg::NUM_BINS; b++) slot_count[slot][b] = 0;
                  slot_live[slot] = 1'b1;
               end
               if (slot_count[slot][bin] < COUNT_FULL) slot_count[slot][bin]++;
               last_hr = it.hour;
               last_min = it.minute;
               r.status = hrtb_pkg::ST_RECORDED;
               r.warning = (bin == 0) ? hrtb_pkg::WARN_LOW
                         : (bin == 4) ? hrtb_pkg::WARN_HIGH : hrtb_pkg::WARN_NONE;
               r.bin_hit = 3'(bin);
               r.counts = slot_view(slot);
            end
         end
         hrtb_pkg::MODE_QUERY_TIME: begin
            slot = slot_index(it.hour, it.minute);
            if (slot < 0) begin
               r.status = hrtb_pkg::ST_BAD_TIME;
            end else begin
               r.status = hrtb_pkg::ST_QUERY_DONE;
               r.counts = slot_view(slot);
            end
         end
         hrtb_pkg::MODE_QUERY_LAST: begin
            r.status = hrtb_pkg::ST_QUERY_DONE;
            r.counts = slot_view(slot_index(last_hr, last_min));
         end
         default: begin
            for (int s = 0; s < hrtb_pkg::NUM_BLOCKS_DEF; s++) slot_live[s] = 1'b0;
            r.status = hrtb_pkg::ST_CLEARED;
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   task automatic compare_result(hist_result_type e, hist_result_type a);
      check_field("status", e.status, a.status);
      check_field("warning", e.warning, a.warning);
      check_field("bin_hit", e.bin_hit, a.bin_hit);
      check_field("count_bin0", e.counts[0], a.counts[0]);
      check_field("count_bin1", e.counts[1], a.counts[1]);
      check_field("count_bin2", e.counts[2], a.counts[2]);
      check_field("count_bin3", e.counts[3], a.counts[3]);
      check_field("count_bin4", e.counts[4], a.counts[4]);
   endtask

   // Score results against the oldest expectation, then predict any item taken now.
   always @(posedge clock) begin
      hist_result_type got;
      hist_result_type want;
      req_item_type    taken;
      if (!reset) begin
         if (rsp_strobe) begin
            got.status = hrtb_pkg::status_type'(rsp_status);
            got.warning = hrtb_pkg::warn_type'(rsp_warning);
            got.bin_hit = rsp_bin_hit;
            got.counts = {rsp_count_bin4, rsp_count_bin3, rsp_count_bin2,
                          rsp_count_bin1, rsp_count_bin0};
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: result with no item pending, expected none, actual status %0d",
                        $time, rsp_status);
            end else begin
               want = pending_results.pop_front();
               compare_result(want, got);
            end
         end
         if (start && !busy) begin
            taken.mode = hrtb_pkg::mode_type'(req_mode);
            taken.rate = req_rate_bpm;
            taken.hour = req_hour;
            taken.minute = req_minute;
            taken.term = req_terminator;
            want = histogram_predict(taken);
            pending_results.push_back(cur_typed ? cur_typed_res : want);
         end
      end
   end

   // Present one item after a gap and hold it until taken. Entered and left at a falling edge.
   task automatic send_item(req_item_type it, int gap, logic typed, hist_result_type tres);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_mode <= it.mode;
      req_rate_bpm <= it.rate;
      req_hour <= it.hour;
      req_minute <= it.minute;
      req_terminator <= it.term;
      cur_typed <= typed;
      cur_typed_res <= tres;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
   endtask

   // Hold the sender off until every expected result has arrived.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(hrtb_pkg::csr_index_type idx, logic [7:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         hrtb_pkg::CSR_EDGE_LOW:    bin_edge[0] = value;
         hrtb_pkg::CSR_EDGE_SECOND: bin_edge[1] = value;
         hrtb_pkg::CSR_EDGE_THIRD:  bin_edge[2] = value;
         default:                   bin_edge[3] = value;
      endcase
      @(negedge clock);
   endtask

   task automatic set_edges(logic [7:0] e0, logic [7:0] e1, logic [7:0] e2, logic [7:0] e3);
      write_csr(hrtb_pkg::CSR_EDGE_LOW, e0);
      write_csr(hrtb_pkg::CSR_EDGE_SECOND, e1);
      write_csr(hrtb_pkg::CSR_EDGE_THIRD, e2);
      write_csr(hrtb_pkg::CSR_EDGE_HIGH, e3);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Sender gap: random, with runs of back-to-back items.
   function automatic int next_gap();
      if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
      return no_idle ? 0 : $urandom_range(0, 18);
   endfunction

   // A random rate, often right at or just past one of the edges.
   function automatic logic [7:0] pick_rate();
      if ($urandom_range(0, 3) == 0)
         return bin_edge[$urandom_range(0, 3)] + 8'($urandom_range(0, 1));
      return 8'($urandom_range(0, 255));
   endfunction

   // Random item: mostly good records, some queries, a few broken frames, bad times and clears.
   function automatic req_item_type gen_item(bit hot);
      req_item_type it;
      int           r;
      it.mode = hrtb_pkg::MODE_RECORD;
      it.rate = pick_rate();
      it.hour = 8'($urandom_range(0, 23));
      it.minute = 8'($urandom_range(0, 59));
      it.term = hrtb_pkg::FRAME_END;
      r = $urandom_range(0, 99);
      if (hot) begin
         // Pile records onto one slot so its counter reaches full scale.
         if (r < 95) begin
            it.hour = 8'(hot_hour);
            it.minute = 8'(hot_quarter * 15 + $urandom_range(0, 14));
         end
         if (r >= 90 && r < 95) it.mode = hrtb_pkg::MODE_QUERY_TIME;
         else if (r >= 95 && r < 98) it.mode = hrtb_pkg::MODE_QUERY_LAST;
      end else begin
         if (r < 30) begin
            it.hour = 8'($urandom_range(0, 3));
         end else if (r >= 58 && r < 66) begin
            it.term = 8'($urandom_range(0, 255));
         end else if (r >= 66 && r < 73) begin
            it.hour = 8'($urandom_range(0, 255));
            it.minute = 8'($urandom_range(0, 255));
         end else if (r >= 73 && r < 83) begin
            it.mode = hrtb_pkg::MODE_QUERY_TIME;
            if (r < 79) it.hour = 8'($urandom_range(0, 3));
         end else if (r >= 83 && r < 88) begin
            it.mode = hrtb_pkg::MODE_QUERY_TIME;
            it.hour = 8'($urandom_range(0, 255));
            it.minute = 8'($urandom_range(0, 255));
         end else if (r >= 88 && r < 96) begin
            it.mode = hrtb_pkg::MODE_QUERY_LAST;
         end else if (r >= 96) begin
            it.mode = hrtb_pkg::MODE_CLEAR;
         end
      end
      // Fields that the mode ignores carry noise.
      if (it.mode != hrtb_pkg::MODE_RECORD) begin
         it.term = 8'($urandom_range(0, 255));
         it.rate = 8'($urandom_range(0, 255));
      end
      return it;
   endfunction

   task automatic plan_row(hrtb_pkg::mode_type m, logic [7:0] rate, logic [7:0] hr,
                           logic [7:0] mn, logic [7:0] term, logic typed,
                           hrtb_pkg::status_type st, hrtb_pkg::warn_type w,
                           logic [2:0] bin, count_set_type counts);
      plan_row_type row;
      row.item = '{mode: m, rate: rate, hour: hr, minute: mn, term: term};
      row.typed = typed;
      row.res = '{status: st, warning: w, bin_hit: bin, counts: counts};
      plan.push_back(row);
   endtask

   // Run time limit.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      req_item_type it;
      int           n;
      bin_edge[0] = hrtb_pkg::EDGE_LOW_RST;
      bin_edge[1] = hrtb_pkg::EDGE_SECOND_RST;
      bin_edge[2] = hrtb_pkg::EDGE_THIRD_RST;
      bin_edge[3] = hrtb_pkg::EDGE_HIGH_RST;
      for (int s = 0; s < hrtb_pkg::NUM_BLOCKS_DEF; s++) begin
         slot_live[s] = 1'b0;
         for (int b = 0; b < hrtb_pkg::NUM_BINS; b++) slot_count[s][b] = 0;
      end
      last_hr = 8'd0;
      last_min = 8'd0;

      // Directed table at the reset edges; typed rows carry their own result.
      plan_row(hrtb_pkg::MODE_QUERY_LAST, 8'd0, 8'd0, 8'd0, 8'd0,
               1, hrtb_pkg::ST_QUERY_DONE, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd0, 8'd0, 8'd0, hrtb_pkg::FRAME_END,
               1, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_LOW, 0,
               {8'd0, 8'd0, 8'd0, 8'd0, 8'd1});
      plan_row(hrtb_pkg::MODE_RECORD, 8'd255, 8'd23, 8'd59, hrtb_pkg::FRAME_END,
               1, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_HIGH, 4,
               {8'd1, 8'd0, 8'd0, 8'd0, 8'd0});
      plan_row(hrtb_pkg::MODE_QUERY_LAST, 8'd0, 8'd0, 8'd0, 8'd0,
               1, hrtb_pkg::ST_QUERY_DONE, hrtb_pkg::WARN_NONE, 0,
               {8'd1, 8'd0, 8'd0, 8'd0, 8'd0});
      plan_row(hrtb_pkg::MODE_RECORD, 8'd40, 8'd0, 8'd14, hrtb_pkg::FRAME_END,
               1, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_LOW, 0,
               {8'd0, 8'd0, 8'd0, 8'd0, 8'd2});
      plan_row(hrtb_pkg::MODE_RECORD, 8'd41, 8'd0, 8'd0, hrtb_pkg::FRAME_END,
               0, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd80, 8'd0, 8'd15, hrtb_pkg::FRAME_END,
               0, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd120, 8'd12, 8'd30, hrtb_pkg::FRAME_END,
               0, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd160, 8'd12, 8'd45, hrtb_pkg::FRAME_END,
               0, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd161, 8'd12, 8'd44, hrtb_pkg::FRAME_END,
               0, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_NONE, 0, '0);
      // Broken frames, including one whose time is also bad: the frame wins.
      plan_row(hrtb_pkg::MODE_RECORD, 8'd255, 8'd0, 8'd0, 8'd0,
               1, hrtb_pkg::ST_BAD_FRAME, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd0, 8'd255, 8'd255, 8'd255,
               1, hrtb_pkg::ST_BAD_FRAME, hrtb_pkg::WARN_NONE, 0, '0);
      // Times out of range.
      plan_row(hrtb_pkg::MODE_RECORD, 8'd90, 8'd24, 8'd0, hrtb_pkg::FRAME_END,
               1, hrtb_pkg::ST_BAD_TIME, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd90, 8'd0, 8'd60, hrtb_pkg::FRAME_END,
               1, hrtb_pkg::ST_BAD_TIME, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd255, 8'd255, 8'd255, hrtb_pkg::FRAME_END,
               1, hrtb_pkg::ST_BAD_TIME, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_QUERY_TIME, 8'd0, 8'd0, 8'd7, 8'd0,
               0, hrtb_pkg::ST_QUERY_DONE, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_QUERY_TIME, 8'd0, 8'd24, 8'd0, 8'd0,
               1, hrtb_pkg::ST_BAD_TIME, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_QUERY_TIME, 8'd0, 8'd5, 8'd255, 8'd0,
               1, hrtb_pkg::ST_BAD_TIME, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_QUERY_TIME, 8'd0, 8'd23, 8'd45, 8'd0,
               0, hrtb_pkg::ST_QUERY_DONE, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_QUERY_TIME, 8'd0, 8'd7, 8'd0, 8'd0,
               1, hrtb_pkg::ST_QUERY_DONE, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_QUERY_TIME, 8'd255, 8'd0, 8'd0, 8'd255,
               0, hrtb_pkg::ST_QUERY_DONE, hrtb_pkg::WARN_NONE, 0, '0);
      // Clear, then reads of emptied slots and a fresh record.
      plan_row(hrtb_pkg::MODE_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255,
               1, hrtb_pkg::ST_CLEARED, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_QUERY_TIME, 8'd0, 8'd0, 8'd0, 8'd0,
               1, hrtb_pkg::ST_QUERY_DONE, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_QUERY_LAST, 8'd0, 8'd0, 8'd0, 8'd0,
               1, hrtb_pkg::ST_QUERY_DONE, hrtb_pkg::WARN_NONE, 0, '0);
      plan_row(hrtb_pkg::MODE_RECORD, 8'd100, 8'd0, 8'd0, hrtb_pkg::FRAME_END,
               0, hrtb_pkg::ST_RECORDED, hrtb_pkg::WARN_NONE, 0, '0);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) send_item(plan[i].item, next_gap(), plan[i].typed, plan[i].res);
      wait_idle();

      // Random phases, each under its own edge setting.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               set_edges(8'd30, 8'd70, 8'd110, 8'd200);
               n = 110;
            end
            1: begin
               set_edges(8'd0, 8'd0, 8'd0, 8'd0);
               n = 60;
            end
            2: begin
               // Every rate lands in bin zero, so the hot slot saturates.
               set_edges(8'd255, 8'd255, 8'd255, 8'd255);
               hot_hour = $urandom_range(0, 23);
               hot_quarter = $urandom_range(0, 3);
               n = 340;
            end
            3: begin
               set_edges(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               n = 80;
            end
            default: begin
               // Edges out of order.
               set_edges(8'd255, 8'd0, 8'd255, 8'd0);
               n = 30;
            end
         endcase
         for (int k = 0; k < n; k++) begin
            it = gen_item(ph == 2);
            send_item(it, next_gap(), 1'b0, '0);
            if ($urandom_range(0, 79) == 0) wait_idle();
         end
         wait_idle();
      end

      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
